// ----- sv/bitcrusher_tone_mix_top_defines.svh -----
// ------------------------------------------------------------------------
// bitcrusher tone mix assertion macros
// shared property forms for the port checker
// ------------------------------------------------------------------------
`ifndef BITCRUSHER_TONE_MIX_TOP_DEFINES_SVH
`define BITCRUSHER_TONE_MIX_TOP_DEFINES_SVH

// same-cycle implication, off while in reset
`define BTM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("btm assertion failed");

// next-cycle implication, off while in reset
`define BTM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("btm assertion failed");

`endif

// ----- sv/btm_pkg.sv -----
// ------------------------------------------------------------------------
// btm_pkg
// types, constants and the tanh table builder for the bitcrusher
// ------------------------------------------------------------------------
package btm_pkg;

  localparam int MAX_HOLD   = 32;
  localparam int HOLD_W     = $clog2(MAX_HOLD);
  localparam int HF_W       = HOLD_W + 1;
  localparam int TANH_DEPTH = 1024;
  localparam int TANH_AW    = $clog2(TANH_DEPTH);

  // exponent step of the tanh table, 8/depth in q32
  localparam logic [95:0] TANH_STEP = (96'd8 << 32) / 96'(TANH_DEPTH);

  localparam int CFG_W  = 17;
  localparam int CIDX_W = 3;

  localparam logic [CIDX_W-1:0] CFG_HOLD  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_QMAX  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_QRCP  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_ASYM  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_DRIVE = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_ALPHA = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_MIX   = 3'd6;

  localparam logic [5:0]  RST_HOLD  = 6'd4;
  localparam logic [14:0] RST_QMAX  = 15'd127;
  localparam logic [16:0] RST_QRCP  = 17'd516;
  localparam logic [15:0] RST_ASYM  = 16'd26214;
  localparam logic [15:0] RST_DRIVE = 16'd27853;
  localparam logic [15:0] RST_ALPHA = 16'd7282;
  localparam logic [16:0] RST_MIX   = 17'd32768;

  typedef enum logic [3:0] {
    S_IDLE,
    S_QNT,
    S_CRU,
    S_ASY,
    S_DRV,
    S_TAB,
    S_TBW,
    S_TONE,
    S_MIX
  } btm_state_t;

  typedef logic [14:0] tanh_rom_t [TANH_DEPTH];

  // shift-subtract quotient, the quotient must fit in qbits
  function automatic logic [95:0] div_shift(logic [95:0] num, logic [95:0] den, int qbits);
    logic [95:0] rem;
    logic [95:0] q;
    rem = num;
    q   = '0;
    for (int b = qbits - 1; b >= 0; b--) begin
      if ((den << b) <= rem) begin
        rem  = rem - (den << b);
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // e steps by exp(-8/depth) in q32, entry = (1-e)/(1+e) in q15
  function automatic tanh_rom_t build_tanh();
    tanh_rom_t          tab;
    logic        [95:0] one;
    logic        [95:0] d;
    logic        [95:0] term;
    logic signed [95:0] r;
    logic        [95:0] e;
    logic        [95:0] num;
    logic        [95:0] den;
    logic        [95:0] v;
    one  = 96'd1 << 32;
    d    = TANH_STEP;
    term = one;
    r    = $signed(one);
    e    = one;
    for (int n = 1; n <= 12; n++) begin
      term = div_shift((term * d) >> 32, 96'(n), 58);
      if (n % 2 == 1) begin
        r = r - $signed(term);
      end else begin
        r = r + $signed(term);
      end
    end
    if (r < 0) begin
      r = '0;
    end
    for (int i = 0; i < TANH_DEPTH; i++) begin
      num = one - e;
      den = one + e;
      v   = div_shift(num * 96'd65536 + den, den << 1, 17);
      if (v > 96'd32767) begin
        v = 96'd32767;
      end
      tab[i] = v[14:0];
      e = (e * $unsigned(r)) >> 32;
    end
    return tab;
  endfunction

endpackage

// ----- sv/bitcrusher_tone_mix_top.sv -----
// ------------------------------------------------------------------------
// bitcrusher_tone_mix_top
// sample-hold bitcrusher with tanh drive, one-pole tone and dry/wet mix
// ------------------------------------------------------------------------
// One request in, one request out. Each sample runs through six multiplies
// on a single shift-add unit that retires one multiplier bit per cycle and
// stops as soon as the remaining multiplier bits are zero, plus the
// registered tanh table read in states S_TAB and S_TBW. Smaller
// coefficients and negative crushed values (which skip the asymmetry pass)
// finish sooner than full-width ones, and the bit-serial multiplier sets
// how long a sample takes. Only one sample is in work at a time, but a
// finished result waiting in the output register does not block the next
// sample from entering; only the final step waits for the output register
// to free up. Configuration writes to an index in the register list clear
// the hold counter, held sample and tone state; they are taken only while
// idle and hold off the input for the cycle of the write.
module bitcrusher_tone_mix_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [15:0]            in_sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            out_sample_out,
  input  logic                          cfg_we,
  input  logic [btm_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [btm_pkg::CFG_W-1:0]     cfg_wdata
);
  import btm_pkg::*;

  localparam tanh_rom_t TANH_ROM = build_tanh();

  btm_state_t state_r, state_nxt;

  // configuration
  logic [5:0]  hold_r, hold_nxt;
  logic [14:0] qmax_r, qmax_nxt;
  logic [16:0] qrcp_r, qrcp_nxt;
  logic [15:0] asym_r, asym_nxt;
  logic [15:0] drive_r, drive_nxt;
  logic [15:0] alpha_r, alpha_nxt;
  logic [16:0] mix_r, mix_nxt;

  // state of the effect
  logic [HOLD_W-1:0]   hcnt_r, hcnt_nxt;
  logic signed [15:0]  held_r, held_nxt;
  logic signed [23:0]  tone_r, tone_nxt;

  // serial multiplier and work registers
  logic [50:0]         ma_r, ma_nxt;
  logic [16:0]         mb_r, mb_nxt;
  logic [50:0]         acc_r, acc_nxt;
  logic                neg_r, neg_nxt;
  logic                dneg_r, dneg_nxt;
  logic signed [15:0]  x_r, x_nxt;
  logic                sat_r, sat_nxt;
  logic [TANH_AW-1:0]  addr_r, addr_nxt;
  logic [14:0]         rom_q_r;

  logic                ov_r, ov_nxt;
  logic signed [15:0]  out_r, out_nxt;

  // hold logic
  logic [HF_W-1:0]     hf_eff;
  logic [HF_W-1:0]     cnt_inc;
  logic                capture;
  logic signed [15:0]  held_new;
  logic [16:0]         h_mag;

  // per-stage results
  logic [30:0]         q_sum;
  logic [48:0]         asy_sum;
  logic [51:0]         drv_sum;
  logic [38:0]         a_val;
  logic [14:0]         w_mag;
  logic signed [15:0]  w_val;
  logic signed [25:0]  diff1;
  logic signed [42:0]  tprod;
  logic signed [26:0]  tadd;
  logic signed [27:0]  z_full;
  logic signed [23:0]  z_new;
  logic signed [25:0]  diff2;
  logic [16:0]         mix_eff;
  logic signed [42:0]  mprod;
  logic signed [43:0]  blend;
  logic signed [19:0]  o_full;
  logic signed [15:0]  o_sat;
  logic                mul_done;
  logic                out_free;

  // a register write takes the idle cycle, so no request is taken with it
  assign in_stall       = (state_r != S_IDLE) || cfg_we;
  assign out_valid      = ov_r;
  assign out_sample_out = out_r;

  assign mul_done = (mb_r == '0);
  assign out_free = !ov_r || !out_stall;

  // hold factor of zero acts as one, large values stop at the maximum
  assign hf_eff = (hold_r == '0) ? HF_W'(1) :
                  (32'(hold_r) > 32'(MAX_HOLD)) ? HF_W'(MAX_HOLD) : HF_W'(hold_r);
  assign cnt_inc  = {1'b0, hcnt_r} + HF_W'(1);
  assign capture  = (cnt_inc >= hf_eff);
  assign held_new = capture ? in_sample_in : held_r;
  assign h_mag    = held_new[15] ? (17'd0 - {held_new[15], held_new}) : {1'b0, held_new};

  // round to level count, then the two gain stages
  assign q_sum   = {1'b0, acc_r[29:0]} + 31'd16384;
  assign asy_sum = {1'b0, acc_r[47:0]} + 49'd8192;
  assign drv_sum = {1'b0, acc_r} + 52'd4096;
  assign a_val   = drv_sum[51:13];

  // shaped value with sign put back
  assign w_mag = sat_r ? 15'h7fff : rom_q_r;
  assign w_val = neg_r ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
  assign diff1 = 26'($signed({w_val, 8'd0})) - 26'(tone_r);

  // one-pole update, floor of value plus half
  assign tprod  = dneg_r ? -$signed({1'b0, acc_r[41:0]}) : $signed({1'b0, acc_r[41:0]});
  assign tadd   = 27'((tprod + 43'sd32768) >>> 16);
  assign z_full = 28'(tone_r) + 28'(tadd);
  assign z_new  = (z_full > 28'sd8388607)  ? 24'sd8388607 :
                  (z_full < -28'sd8388608) ? -24'sd8388608 : z_full[23:0];
  assign diff2  = 26'(z_new) - 26'($signed({x_r, 8'd0}));

  // dry/wet blend
  assign mix_eff = (mix_r > 17'd65536) ? 17'd65536 : mix_r;
  assign mprod   = dneg_r ? -$signed({1'b0, acc_r[41:0]}) : $signed({1'b0, acc_r[41:0]});
  assign blend   = $signed({x_r[15], x_r, 24'd0}) + 44'(mprod) + 44'sd8388608;
  assign o_full  = 20'(blend >>> 24);
  assign o_sat   = (o_full > 20'sd32767)  ? 16'sh7fff :
                   (o_full < -20'sd32768) ? 16'sh8000 : o_full[15:0];

  always_comb begin
    state_nxt = state_r;
    hold_nxt  = hold_r;
    qmax_nxt  = qmax_r;
    qrcp_nxt  = qrcp_r;
    asym_nxt  = asym_r;
    drive_nxt = drive_r;
    alpha_nxt = alpha_r;
    mix_nxt   = mix_r;
    hcnt_nxt  = hcnt_r;
    held_nxt  = held_r;
    tone_nxt  = tone_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    dneg_nxt  = dneg_r;
    x_nxt     = x_r;
    sat_nxt   = sat_r;
    addr_nxt  = addr_r;
    ov_nxt    = ov_r;
    out_nxt   = out_r;

    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    // shift-add step: one multiplier bit a cycle
    if (!mul_done) begin
      acc_nxt = acc_r + (mb_r[0] ? ma_r : '0);
      ma_nxt  = {ma_r[49:0], 1'b0};
      mb_nxt  = {1'b0, mb_r[16:1]};
    end

    unique case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          // an index past the register list is dropped and keeps the state
          if (cfg_index <= CFG_MIX) begin
            unique case (cfg_index)
              CFG_HOLD:  hold_nxt  = cfg_wdata[5:0];
              CFG_QMAX:  qmax_nxt  = cfg_wdata[14:0];
              CFG_QRCP:  qrcp_nxt  = cfg_wdata[16:0];
              CFG_ASYM:  asym_nxt  = cfg_wdata[15:0];
              CFG_DRIVE: drive_nxt = cfg_wdata[15:0];
              CFG_ALPHA: alpha_nxt = cfg_wdata[15:0];
              default:   mix_nxt   = cfg_wdata[16:0];
            endcase
            hcnt_nxt = '0;
            held_nxt = '0;
            tone_nxt = '0;
          end
        end else if (in_valid) begin
          hcnt_nxt  = capture ? '0 : cnt_inc[HOLD_W-1:0];
          held_nxt  = held_new;
          x_nxt     = in_sample_in;
          neg_nxt   = held_new[15];
          ma_nxt    = 51'(h_mag);
          mb_nxt    = {2'b0, qmax_r};
          acc_nxt   = '0;
          state_nxt = S_QNT;
        end
      end
      S_QNT: begin
        if (mul_done) begin
          ma_nxt    = 51'(q_sum[29:15]);
          mb_nxt    = qrcp_r;
          acc_nxt   = '0;
          state_nxt = S_CRU;
        end
      end
      S_CRU: begin
        if (mul_done) begin
          ma_nxt  = 51'(acc_r[31:0]);
          acc_nxt = '0;
          if (neg_r && (acc_r[31:0] != '0)) begin
            mb_nxt    = {1'b0, drive_r};
            state_nxt = S_DRV;
          end else begin
            // zero crush gives sign positive either way
            neg_nxt   = 1'b0;
            mb_nxt    = {1'b0, asym_r};
            state_nxt = S_ASY;
          end
        end
      end
      S_ASY: begin
        if (mul_done) begin
          ma_nxt    = 51'(asy_sum[47:14]);
          mb_nxt    = {1'b0, drive_r};
          acc_nxt   = '0;
          state_nxt = S_DRV;
        end
      end
      S_DRV: begin
        if (mul_done) begin
          sat_nxt   = (a_val[38:18] != '0);
          addr_nxt  = a_val[17 -: TANH_AW];
          state_nxt = S_TAB;
        end
      end
      S_TAB: begin
        state_nxt = S_TBW;
      end
      S_TBW: begin
        dneg_nxt  = diff1[25];
        ma_nxt    = 51'(diff1[25] ? -diff1 : diff1);
        mb_nxt    = {1'b0, alpha_r};
        acc_nxt   = '0;
        state_nxt = S_TONE;
      end
      S_TONE: begin
        if (mul_done) begin
          tone_nxt  = z_new;
          dneg_nxt  = diff2[25];
          ma_nxt    = 51'(diff2[25] ? -diff2 : diff2);
          mb_nxt    = mix_eff;
          acc_nxt   = '0;
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        if (mul_done && out_free) begin
          out_nxt   = o_sat;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= RST_HOLD;
      qmax_r  <= RST_QMAX;
      qrcp_r  <= RST_QRCP;
      asym_r  <= RST_ASYM;
      drive_r <= RST_DRIVE;
      alpha_r <= RST_ALPHA;
      mix_r   <= RST_MIX;
      hcnt_r  <= '0;
      held_r  <= '0;
      tone_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      hold_r  <= hold_nxt;
      qmax_r  <= qmax_nxt;
      qrcp_r  <= qrcp_nxt;
      asym_r  <= asym_nxt;
      drive_r <= drive_nxt;
      alpha_r <= alpha_nxt;
      mix_r   <= mix_nxt;
      hcnt_r  <= hcnt_nxt;
      held_r  <= held_nxt;
      tone_r  <= tone_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    acc_r  <= acc_nxt;
    neg_r  <= neg_nxt;
    dneg_r <= dneg_nxt;
    x_r    <= x_nxt;
    sat_r  <= sat_nxt;
    addr_r <= addr_nxt;
    out_r  <= out_nxt;
  end

  // tanh table, registered read
  always_ff @(posedge clk) begin
    rom_q_r <= TANH_ROM[addr_r];
  end

endmodule

// ----- sv/btm_checker.sv -----
// ------------------------------------------------------------------------
// btm_checker
// port-level checks on request flow of the bitcrusher
// ------------------------------------------------------------------------
`include "bitcrusher_tone_mix_top_defines.svh"

module btm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [15:0]         out_sample_out
);
  logic [1:0] pend_r, pend_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    pend_nxt = pend_r + 2'(in_acc) - 2'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `BTM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_sample_out))
  `BTM_ASSERT_IMP(a_no_phantom, out_valid, pend_r != 2'd0)
  `BTM_ASSERT_IMP(a_one_in_work, in_acc, pend_r != 2'd2)

endmodule

bind bitcrusher_tone_mix_top btm_checker u_btm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_sample_out (out_sample_out)
);

// ----- test/bitcrusher_tone_mix_top_tb.sv -----
// ------------------------------------------------------------------------
// bitcrusher_tone_mix_top_tb
// self-checking bench: directed corner requests, then random configuration
// phases with bursty senders and a patterned output stall
// ------------------------------------------------------------------------
module bitcrusher_tone_mix_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import btm_pkg::*;

  // settle wait, longer than the worst sample takes inside the block
  localparam int SETTLE_CYCLES = 160;
  localparam int TAB_DEPTH     = 1024;

  // an index past the register list
  localparam logic [CIDX_W-1:0] CFG_BAD = 3'd7;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [15:0]        in_sample_in;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [15:0]        out_sample_out;
  logic                      cfg_we;
  logic [CIDX_W-1:0]         cfg_index;
  logic [CFG_W-1:0]          cfg_wdata;

  bitcrusher_tone_mix_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // ---------------------------------------------------------------------
  // shadow copy of the block: settings, state and the tanh curve
  // ---------------------------------------------------------------------
  logic [5:0]         sh_hold;
  logic [14:0]        sh_qmax;
  logic [16:0]        sh_qrcp;
  logic [15:0]        sh_asym;
  logic [15:0]        sh_drive;
  logic [15:0]        sh_alpha;
  logic [16:0]        sh_mix;
  int                 sh_count;
  logic signed [15:0] sh_held;
  longint             sh_tone;
  int                 tanh_curve [TAB_DEPTH];

  logic signed [15:0] crushed_q [$];
  int                 n_errors;
  int                 n_sent;
  int                 n_checked;
  int                 burst_left;

  // decaying exponential in q32 gives (1-e)/(1+e) per entry
  task automatic make_tanh_curve();
    logic [127:0] one;
    logic [127:0] step_d;
    logic [127:0] term;
    logic [127:0] e;
    logic [127:0] v;
    longint       ratio;
    one    = 128'd1 << 32;
    step_d = (128'd8 << 32) / TAB_DEPTH;
    term   = one;
    ratio  = longint'(one);
    e      = one;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * step_d) >> 32) / n;
      if (n % 2 == 1) begin
        ratio -= longint'(term);
      end else begin
        ratio += longint'(term);
      end
    end
    if (ratio < 0) ratio = 0;
    for (int i = 0; i < TAB_DEPTH; i++) begin
      v = ((one - e) * 65536 + (one + e)) / (2 * (one + e));
      tanh_curve[i] = (v > 32767) ? 32767 : int'(v);
      e = (e * 128'(ratio)) >> 32;
    end
  endtask

  task automatic clear_shadow();
    sh_count = 0;
    sh_held  = '0;
    sh_tone  = 0;
  endtask

  // one sample through hold, quantiser, drive, tanh, tone and blend
  function automatic logic signed [15:0] crush_sample(logic signed [15:0] x);
    int     hf;
    longint p, mag, c, a, w, z, mix, acc, o;
    hf  = (sh_hold < 1) ? 1 : (sh_hold > MAX_HOLD) ? MAX_HOLD : int'(sh_hold);
    mix = (sh_mix > 65536) ? 65536 : longint'(sh_mix);
    sh_count++;
    if (sh_count >= hf) begin
      sh_count = 0;
      sh_held  = x;
    end
    p   = longint'(sh_held) * longint'(sh_qmax);
    mag = ((p < 0 ? -p : p) + 16384) >> 15;
    c   = mag * longint'(sh_qrcp);
    if (p < 0) c = -c;
    if (c > 0) c = (c * longint'(sh_asym) + 8192) >> 14;
    mag = (c < 0) ? -c : c;
    a   = (mag * longint'(sh_drive) + 4096) >> 13;
    w   = (a >= 262144) ? 32767 : tanh_curve[(a * TAB_DEPTH) / 262144];
    if (c < 0) w = -w;
    z = sh_tone;
    z = z + ((longint'(sh_alpha) * (w * 256 - z) + 32768) >>> 16);
    if (z > 8388607) z = 8388607;
    if (z < -8388608) z = -8388608;
    sh_tone = z;
    acc = longint'(x) * 16777216 + mix * (z - longint'(x) * 256);
    o   = (acc + 8388608) >>> 24;
    if (o > 32767) o = 32767;
    if (o < -32768) o = -32768;
    return o[15:0];
  endfunction

  // ---------------------------------------------------------------------
  // clock, reset and watchdog
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // output side: stall on a changing pattern, check every accepted request
  // ---------------------------------------------------------------------
  int stall_mode;
  int stall_left;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 9) < 3);
      2:       out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= ~out_stall;
    endcase
  end

  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (crushed_q.size() == 0) begin
        report_mismatch("unexpected request", out_sample_out, 0);
      end else begin
        if (out_sample_out !== crushed_q[0])
          report_mismatch("sample_out", out_sample_out, crushed_q[0]);
        void'(crushed_q.pop_front());
        n_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // input side: bursts of requests with random gaps
  // ---------------------------------------------------------------------
  task automatic send_sample(logic signed [15:0] x);
    in_valid     <= 1'b1;
    in_sample_in <= x;
    do @(posedge clk); while (in_stall);
    crushed_q = {crushed_q, crush_sample(x)};
    n_sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
    end else begin
      burst_left--;
    end
  endtask

  // stop sending, let every result drain, then let the block settle
  task automatic wait_idle();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (crushed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // registers are only written with the block idle; a write to a listed index clears state
  task automatic write_reg(logic [CIDX_W-1:0] idx, int val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HOLD:  sh_hold  = val[5:0];
      CFG_QMAX:  sh_qmax  = val[14:0];
      CFG_QRCP:  sh_qrcp  = val[16:0];
      CFG_ASYM:  sh_asym  = val[15:0];
      CFG_DRIVE: sh_drive = val[15:0];
      CFG_ALPHA: sh_alpha = val[15:0];
      CFG_MIX:   sh_mix   = val[16:0];
      default:   return;
    endcase
    clear_shadow();
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'($urandom_range(0, 64)) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------
  task automatic test_reset_values();
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    for (int i = 0; i < 5; i++) send_sample(rand_sample());
  endtask

  // hold of zero and above the limit, no levels, oversize reciprocal and mix,
  // an index past the register list, then zero reciprocal, mix and alpha
  task automatic test_corner_settings();
    write_reg(CFG_HOLD, 0);
    write_reg(CFG_QMAX, 0);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    write_reg(CFG_QMAX, 32767);
    write_reg(CFG_QRCP, 131071);
    write_reg(CFG_MIX, 131071);
    write_reg(CFG_ALPHA, 65535);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sd100);
    write_reg(CFG_HOLD, 63);
    write_reg(CFG_ASYM, 49152);
    write_reg(CFG_DRIVE, 57344);
    for (int i = 0; i < 6; i++) send_sample(rand_sample());
    write_reg(CFG_BAD, 17'h1abcd);
    send_sample(16'sh4000);
    write_reg(CFG_QRCP, 0);
    write_reg(CFG_MIX, 0);
    write_reg(CFG_ALPHA, 0);
    write_reg(CFG_ASYM, 16384);
    write_reg(CFG_DRIVE, 8192);
    write_reg(CFG_HOLD, 1);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
  endtask

  // random phases, each with a fresh set of register values
  task automatic test_random_phases();
    int len;
    for (int ph = 0; ph < 20; ph++) begin
      write_reg(CFG_HOLD, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(1, 8));
      write_reg(CFG_QMAX, ($urandom_range(0, 1)) ? (1 << $urandom_range(0, 15)) - 1
                                                 : $urandom_range(0, 32767));
      write_reg(CFG_QRCP, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 131071)
                                                      : $urandom_range(0, 65536));
      write_reg(CFG_ASYM, $urandom_range(16384, 49152));
      write_reg(CFG_DRIVE, $urandom_range(8192, 57344));
      write_reg(CFG_ALPHA, $urandom_range(0, 65535));
      write_reg(CFG_MIX, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 131071)
                                                     : $urandom_range(0, 65536));
      len = $urandom_range(30, 70);
      for (int i = 0; i < len; i++) send_sample(rand_sample());
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    out_stall    = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    stall_mode   = 0;
    stall_left   = 0;
    n_errors     = 0;
    n_sent       = 0;
    n_checked    = 0;
    burst_left   = 0;
    sh_hold  = RST_HOLD;
    sh_qmax  = RST_QMAX;
    sh_qrcp  = RST_QRCP;
    sh_asym  = RST_ASYM;
    sh_drive = RST_DRIVE;
    sh_alpha = RST_ALPHA;
    sh_mix   = RST_MIX;
    clear_shadow();
    make_tanh_curve();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_corner_settings();
    test_random_phases();
    wait_idle();

    $display("ran %0d samples, %0d results checked, over 20 random register sets",
             n_sent, n_checked);
    $display("corners: hold 0 and 63, no levels, oversize reciprocal and mix, bad index");
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/btm_pkg.sv
sv/bitcrusher_tone_mix_top.sv
sv/btm_checker.sv
test/bitcrusher_tone_mix_top_tb.sv
